// File: rtl/gear_content_defined_chunker_defines.svh
// Assertion macros for the chunker checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef GEAR_CONTENT_DEFINED_CHUNKER_DEFINES_SVH
`define GEAR_CONTENT_DEFINED_CHUNKER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define GCDC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("gcdc check failed");

// Check an implication on every rising edge outside reset.
`define GCDC_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("gcdc check failed");

// Check a next-cycle implication on every rising edge outside reset.
`define GCDC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("gcdc check failed");

`endif

// File: rtl/gcdc_pkg.sv
// Package for the gear-hash chunker: field widths, codes, control structs and
// the gear constant table. No dependencies.
package gcdc_pkg;

    localparam int BYTE_W   = 8;
    localparam int HASH_W   = 64;
    localparam int OFFSET_W = 32;
    localparam int LENGTH_W = 23;
    localparam int MIN_W    = 21;
    localparam int AVG_W    = 21;
    localparam int MAX_W    = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 56;

    localparam logic [MIN_W-1:0] MIN_RESET  = MIN_W'(2048);
    localparam logic [AVG_W-1:0] MASK_RESET = AVG_W'(8191);
    localparam logic [MAX_W-1:0] MAX_RESET  = MAX_W'(32768);

    localparam logic [63:0] GEAR_SEED = 64'h243f6a8885a308d3;
    localparam logic [63:0] MIX_INC   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEN = 2'd0,
        CFG_AVG_LEN = 2'd1,
        CFG_MAX_LEN = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ST_EMPTY  = 1'b0,
        ST_LOADED = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_busy;
    } dp_status_t;

    typedef logic [255:0][HASH_W-1:0] gear_table_t;

    // Evaluated at elaboration only.
    function automatic logic [HASH_W-1:0] gear_mix(input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = {56'd0, b} + GEAR_SEED + MIX_INC;
        x = (x ^ (x >> 30)) * MIX_MUL1;
        x = (x ^ (x >> 27)) * MIX_MUL2;
        return x ^ (x >> 31);
    endfunction

    function automatic gear_table_t gear_table_build();
        gear_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = gear_mix(BYTE_W'(i));
        end
        return t;
    endfunction

    localparam gear_table_t GEAR_TABLE = gear_table_build();

endpackage

// File: rtl/gcdc_ctrl.sv
// Controller for the gear-hash chunker: tracks the input stage and issues
// load, step and output-load commands. Depends on gcdc_pkg.
module gcdc_ctrl
    import gcdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (cmd.load) begin
                    state_next = ST_LOADED;
                end
            end
            ST_LOADED: begin
                if (cmd.load) begin
                    state_next = ST_LOADED;
                end else if (cmd.step) begin
                    state_next = ST_EMPTY;
                end
            end
            default: begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_EMPTY: begin
                s_tready = 1'b1;
            end
            ST_LOADED: begin
                // hold the staged byte while its result has nowhere to go
                cmd.step     = !(status.emit && status.out_busy);
                cmd.out_load = cmd.step && status.emit;
                s_tready     = cmd.step;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
    end

endmodule

// File: rtl/gcdc_dp.sv
// Datapath for the gear-hash chunker: configuration registers, input stage,
// rolling hash, chunk bookkeeping and output register. Depends on gcdc_pkg.
module gcdc_dp
    import gcdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    logic [MIN_W-1:0]    min_reg;
    logic [AVG_W-1:0]    mask_reg;
    logic [MAX_W-1:0]    max_reg;

    logic [HASH_W-1:0]   gear_reg;
    logic                last_reg;

    logic [HASH_W-1:0]   hash_reg;
    logic [HASH_W-1:0]   hash_next;
    logic [LENGTH_W-1:0] len_reg;
    logic [LENGTH_W-1:0] len_next;
    logic [OFFSET_W-1:0] start_reg;
    logic [OFFSET_W-1:0] start_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [LENGTH_W-1:0] out_length_reg;
    logic                out_final_reg;

    logic [HASH_W-1:0]   hash_step;
    logic [LENGTH_W-1:0] length;
    logic                cut;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= MIN_RESET;
            mask_reg <= MASK_RESET;
            max_reg  <= MAX_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MIN_LEN: min_reg  <= cfg_wr_data[MIN_W-1:0];
                CFG_AVG_LEN: mask_reg <= cfg_wr_data[AVG_W-1:0] - AVG_W'(1);
                CFG_MAX_LEN: max_reg  <= cfg_wr_data[MAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gear_reg <= GEAR_TABLE[s_tdata];
            last_reg <= s_tlast;
        end
    end

    assign hash_step = {hash_reg[HASH_W-2:0], 1'b0} + gear_reg;
    assign length    = len_reg + LENGTH_W'(1);
    assign cut       = (length >= LENGTH_W'(min_reg))
                    && ((length >= max_reg) || ((hash_step[AVG_W-1:0] & mask_reg) == '0));

    assign status.emit     = cut || last_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

    always_comb begin
        hash_next  = hash_reg;
        len_next   = len_reg;
        start_next = start_reg;
        if (cmd.step) begin
            if (last_reg) begin
                hash_next  = '0;
                len_next   = '0;
                start_next = '0;
            end else if (cut) begin
                hash_next  = '0;
                len_next   = '0;
                start_next = start_reg + OFFSET_W'(length);
            end else begin
                hash_next  = hash_step;
                len_next   = length;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= '0;
            len_reg   <= '0;
            start_reg <= '0;
        end else begin
            hash_reg  <= hash_next;
            len_reg   <= len_next;
            start_reg <= start_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_offset_reg <= start_reg;
            out_length_reg <= length;
            out_final_reg  <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_length_reg, out_offset_reg};
    assign m_tlast  = out_final_reg;

endmodule

// File: rtl/gear_content_defined_chunker.sv
// Gear-hash content-defined chunker, top level.
// Depends on gcdc_pkg, gcdc_ctrl and gcdc_dp.
//
// Input stream: one data byte per request on s_tdata[7:0]; s_tlast marks the
// final byte of a stream. Output stream: one request per chunk, m_tdata holds
// the chunk offset in [31:0] and the chunk length in [54:32]; m_tlast marks
// the chunk that closes the stream.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_wr_index
// (0 minimum length, 1 average length, 2 maximum length); write only while idle.
// Path: an accepted byte is held in the input stage register; when it closes a chunk,
// the chunk result is loaded into the output register as the staged byte steps.
// Throughput: one byte per cycle; the staged byte waits only when it closes a
// chunk and the output register still holds an untaken chunk.
// Reset: aresetn low at a clock edge clears the hash, length, start offset and
// output valid and restores default lengths.
// Stall: while m_tready is low a result is held in the output register, and
// input keeps flowing until a second result would need that register.
module gear_content_defined_chunker
    import gcdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] chunk_offset, [54:32] chunk_length
    output logic                  m_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gcdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gcdc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// File: rtl/gcdc_checker.sv
// Port-level checker for the gear-hash chunker, bound to the top level.
// Depends on gcdc_pkg and gear_content_defined_chunker_defines.svh.
`include "gear_content_defined_chunker_defines.svh"

module gcdc_checker
    import gcdc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tlast
);

    logic out_stall;
    logic in_accept;

    assign out_stall = m_tvalid && !m_tready;
    assign in_accept = s_tvalid && s_tready;

    `GCDC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `GCDC_ASSERT_IMPL(a_len_nonzero, m_tvalid, m_tdata[54:32] != 23'd0)
    `GCDC_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[55] == 1'b0)
    `GCDC_ASSERT_IMPL(a_result_cause, $rose(m_tvalid), $past(in_accept, 2))

endmodule

bind gear_content_defined_chunker gcdc_checker u_gcdc_checker (.*);
